### src/torus_hop_traffic_accumulator_core_assert.svh
// Assertion macros shared by the torus hop accumulator RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef TORUS_HOP_TRAFFIC_ACCUMULATOR_CORE_ASSERT_SVH
`define TORUS_HOP_TRAFFIC_ACCUMULATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, switched off while reset is high.
`define THA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("torus hop accumulator: check failed");
// Clocked check that also holds through reset.
`define THA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("torus hop accumulator: check failed");
`else
`define THA_ASSERT(label, clk, rst, prop)
`define THA_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

### src/tha_pkg.sv
// Shared constants, types and constant-divide helpers for the torus hop accumulator.
// No dependencies; used by every module of the block.
package tha_pkg;

  // Machine geometry
  localparam int NODES_X        = 25;
  localparam int NODES_Y        = 32;
  localparam int NODES_Z        = 24;
  localparam int MAX_THREADS    = 64;
  localparam int CPUS_PER_NODE  = 2;
  localparam int LOCAL_CROSS_HOPS = 2;
  localparam int THR_RESET      = 16;

  // Field widths
  localparam int RANK_W     = 22;
  localparam int BYTES_W    = 32;
  localparam int TOTAL_W    = 64;
  localparam int HOPS_OUT_W = 6;
  localparam int THR_W      = 7;

  localparam int IN_FIELDS_W  = 2 * RANK_W + BYTES_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = HOPS_OUT_W + 3 * TOTAL_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Derived geometry widths
  localparam int NODES_XY  = NODES_X * NODES_Y;
  localparam int NODES_ALL = NODES_XY * NODES_Z;
  localparam int NODE_W    = (NODES_ALL > 1) ? $clog2(NODES_ALL) : 1;
  localparam int MZ_W      = (NODES_XY > 1) ? $clog2(NODES_XY) : 1;
  localparam int AXIS_MAX  = (NODES_X > NODES_Y) ?
                             ((NODES_X > NODES_Z) ? NODES_X : NODES_Z) :
                             ((NODES_Y > NODES_Z) ? NODES_Y : NODES_Z);
  localparam int COORD_W   = $clog2(AXIS_MAX + 1);
  localparam int HOP_MAX   = LOCAL_CROSS_HOPS + NODES_X / 2 + NODES_Y / 2 + NODES_Z / 2;
  localparam int HOP_W     = $clog2(HOP_MAX + 1);
  localparam int PROD_W    = HOP_W + BYTES_W;

  // Thread count and machine size
  localparam int TCNT_W   = $clog2(MAX_THREADS + 1);
  localparam int MACH_MAX = NODES_ALL * CPUS_PER_NODE * MAX_THREADS;
  localparam int MACH_W   = $clog2(MACH_MAX + 1);
  localparam int CMP_W    = (MACH_W > RANK_W) ? MACH_W : RANK_W;

  // Shared divider: two quotient bits per step
  localparam int DIV_BITS  = 2;
  localparam int DIV_STEPS = (RANK_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_W     = DIV_STEPS * DIV_BITS;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);
  localparam int REM_W     = TCNT_W + 1;

  // Reciprocals for the fixed axis divisors; the guard bits keep the
  // estimate exact for every value of the operand width
  localparam int     RECIP_GUARD = COORD_W + 1;
  localparam int     RZ_S    = NODE_W + RECIP_GUARD;
  localparam int     RZ_W    = RZ_S + 1;
  localparam longint RECIP_Z = ((longint'(1) << RZ_S) / NODES_Z) + 1;
  localparam int     RY_S    = MZ_W + RECIP_GUARD;
  localparam int     RY_W    = RY_S + 1;
  localparam longint RECIP_Y = ((longint'(1) << RY_S) / NODES_Y) + 1;

  typedef struct packed {
    logic clear;  // zero all totals
    logic start;  // take hops and bytes for this record
    logic skip;   // record flagged: leave totals alone
  } acc_ctrl_t;

  // node / NODES_Z
  function automatic logic [MZ_W-1:0] div_nodes_z(input logic [NODE_W-1:0] v);
    logic [NODE_W+RZ_W-1:0] p;
    p = (NODE_W+RZ_W)'(v) * (NODE_W+RZ_W)'(RECIP_Z);
    return MZ_W'(p >> RZ_S);
  endfunction

  // column / NODES_Y
  function automatic logic [COORD_W-1:0] div_nodes_y(input logic [MZ_W-1:0] v);
    logic [MZ_W+RY_W-1:0] p;
    p = (MZ_W+RY_W)'(v) * (MZ_W+RY_W)'(RECIP_Y);
    return COORD_W'(p >> RY_S);
  endfunction

endpackage

### src/tha_div.sv
// Shared restoring divider: rank / threads, two quotient bits per cycle.
// Depends on tha_pkg.
module tha_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tha_pkg::RANK_W-1:0]    dividend,
  input  logic [tha_pkg::TCNT_W-1:0]    divisor,
  output logic                          done,
  output logic [tha_pkg::RANK_W-1:0]    quotient
);

  logic                          busy;
  logic [tha_pkg::DCNT_W-1:0]    cnt;
  logic [tha_pkg::REM_W-1:0]     rem;
  logic [tha_pkg::REM_W-1:0]     rem_next;
  logic [tha_pkg::DIV_W-1:0]     quo;
  logic [tha_pkg::DIV_W-1:0]     quo_next;

  // one step: shift in two dividend bits, subtracting where each fits
  always_comb begin
    logic [tha_pkg::REM_W-1:0] r;
    rem_next = rem;
    quo_next = quo;
    for (int k = 0; k < tha_pkg::DIV_BITS; k++) begin
      r        = {rem_next[tha_pkg::REM_W-2:0], quo_next[tha_pkg::DIV_W-1]};
      quo_next = {quo_next[tha_pkg::DIV_W-2:0], 1'b0};
      if (r >= tha_pkg::REM_W'(divisor)) begin
        r           = r - tha_pkg::REM_W'(divisor);
        quo_next[0] = 1'b1;
      end
      rem_next = r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= tha_pkg::DCNT_W'(tha_pkg::DIV_STEPS);
        rem  <= '0;
        quo  <= tha_pkg::DIV_W'(dividend);
      end else if (busy) begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt - tha_pkg::DCNT_W'(1);
        if (cnt == tha_pkg::DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo[tha_pkg::RANK_W-1:0];

endmodule

### src/tha_coord.sv
// Node number to torus coordinates and wrap-aware hop count for two nodes.
// Depends on tha_pkg (reciprocal helpers, geometry widths).
module tha_coord (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [tha_pkg::NODE_W-1:0]    node_a,
  input  logic [tha_pkg::NODE_W-1:0]    node_b,
  output logic                          out_valid,
  output logic [tha_pkg::HOP_W-1:0]     hop_sum
);

  localparam int LANES  = 2;
  localparam int STAGES = 4;

  logic [tha_pkg::NODE_W-1:0]  node_in [LANES];
  logic [tha_pkg::NODE_W-1:0]  n1      [LANES];
  logic [tha_pkg::MZ_W-1:0]    m1      [LANES];
  logic [tha_pkg::MZ_W-1:0]    m2      [LANES];
  logic [tha_pkg::COORD_W-1:0] z2      [LANES];
  logic [tha_pkg::COORD_W-1:0] x2      [LANES];
  logic [tha_pkg::COORD_W-1:0] x3      [LANES];
  logic [tha_pkg::COORD_W-1:0] y3      [LANES];
  logic [tha_pkg::COORD_W-1:0] z3      [LANES];
  logic [STAGES-1:0]           vpipe;

  function automatic logic [tha_pkg::COORD_W-1:0] ring_dist(
    input logic [tha_pkg::COORD_W-1:0] a,
    input logic [tha_pkg::COORD_W-1:0] b,
    input logic [tha_pkg::COORD_W-1:0] n
  );
    logic [tha_pkg::COORD_W-1:0] d;
    logic [tha_pkg::COORD_W-1:0] w;
    d = (a > b) ? (a - b) : (b - a);
    w = n - d;
    return (w < d) ? w : d;
  endfunction

  assign node_in[0] = node_a;
  assign node_in[1] = node_b;

  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      // split off z
      n1[i] <= node_in[i];
      m1[i] <= tha_pkg::div_nodes_z(node_in[i]);
      m2[i] <= m1[i];
      z2[i] <= tha_pkg::COORD_W'(n1[i] - tha_pkg::NODE_W'(m1[i] * tha_pkg::NODES_Z));
      x2[i] <= tha_pkg::div_nodes_y(m1[i]);
      // split the column into x and y
      x3[i] <= x2[i];
      z3[i] <= z2[i];
      y3[i] <= tha_pkg::COORD_W'(m2[i] - tha_pkg::MZ_W'(x2[i] * tha_pkg::NODES_Y));
    end
    hop_sum <= tha_pkg::HOP_W'(tha_pkg::LOCAL_CROSS_HOPS)
             + tha_pkg::HOP_W'(ring_dist(x3[0], x3[1], tha_pkg::COORD_W'(tha_pkg::NODES_X)))
             + tha_pkg::HOP_W'(ring_dist(y3[0], y3[1], tha_pkg::COORD_W'(tha_pkg::NODES_Y)))
             + tha_pkg::HOP_W'(ring_dist(z3[0], z3[1], tha_pkg::COORD_W'(tha_pkg::NODES_Z)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[STAGES-2:0], in_valid};
    end
  end

  assign out_valid = vpipe[STAGES-1];

endmodule

### src/tha_acc.sv
// Saturating traffic totals: local, remote and hop-weighted byte sums.
// Depends on tha_pkg (acc_ctrl_t, widths).
module tha_acc (
  input  logic                          clk,
  input  logic                          rst,
  input  tha_pkg::acc_ctrl_t            ctrl,
  input  logic [tha_pkg::HOP_W-1:0]     hops,
  input  logic [tha_pkg::BYTES_W-1:0]   msg_bytes,
  output logic                          done,
  output logic [tha_pkg::TOTAL_W-1:0]   local_total,
  output logic [tha_pkg::TOTAL_W-1:0]   remote_total,
  output logic [tha_pkg::TOTAL_W-1:0]   hop_byte_total
);

  logic                          busy;
  logic                          skip_q;
  logic                          zero_hops;
  logic [tha_pkg::BYTES_W-1:0]   bytes_q;
  logic [tha_pkg::PROD_W-1:0]    prod;

  function automatic logic [tha_pkg::TOTAL_W-1:0] sat_add(
    input logic [tha_pkg::TOTAL_W-1:0] a,
    input logic [tha_pkg::TOTAL_W-1:0] b
  );
    logic [tha_pkg::TOTAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[tha_pkg::TOTAL_W] ? '1 : s[tha_pkg::TOTAL_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      done           <= 1'b0;
      local_total    <= '0;
      remote_total   <= '0;
      hop_byte_total <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.clear) begin
        local_total    <= '0;
        remote_total   <= '0;
        hop_byte_total <= '0;
      end
      // first step: weight bytes by hops
      if (ctrl.start) begin
        busy      <= 1'b1;
        skip_q    <= ctrl.skip;
        zero_hops <= (hops == '0);
        bytes_q   <= msg_bytes;
        prod      <= tha_pkg::PROD_W'(hops) * tha_pkg::PROD_W'(msg_bytes);
      end
      // second step: add into the totals
      if (busy) begin
        busy <= 1'b0;
        done <= 1'b1;
        if (!skip_q) begin
          if (zero_hops) begin
            local_total <= sat_add(local_total, tha_pkg::TOTAL_W'(bytes_q));
          end else begin
            remote_total   <= sat_add(remote_total, tha_pkg::TOTAL_W'(bytes_q));
            hop_byte_total <= sat_add(hop_byte_total, tha_pkg::TOTAL_W'(prod));
          end
        end
      end
    end
  end

endmodule

### src/torus_hop_traffic_accumulator_core.sv
// Top level of the torus hop traffic accumulator.
// Depends on tha_pkg, tha_div, tha_coord, tha_acc and the assertion header.
//
// Takes one message record per transaction (source rank, destination rank,
// byte count, first-record flag) and returns one result transaction holding
// the record's hop count and the three running totals after it. Ranks map
// onto nodes of a 25 x 32 x 24 torus, two CPUs per node, a configurable
// number of ranks per CPU (written on the cfg channel, reset 16; zero acts
// as one and anything above 64 as 64). A record works through one item at a
// time: an in-range record makes two passes through the shared divider
// (rank / threads, eleven steps of two quotient bits per pass), then goes
// through the four-stage coordinate pipeline, is multiplied and added into
// the saturating totals and is loaded into the output register. A record
// with a rank beyond the machine is flagged on tuser, reports zero hops,
// leaves the totals unchanged (the first-record clear still applies) and
// bypasses the divider and the coordinate pipeline. The input side stays
// closed while a record is in flight; a finished result sits in the output
// register until taken, and the next record may be accepted meanwhile. A
// result still waiting there stalls the following record at its last step
// until the output side takes it. Write cfg only while idle.
`include "torus_hop_traffic_accumulator_core_assert.svh"
module torus_hop_traffic_accumulator_core (
  input  logic                              clk,
  input  logic                              rst,
  // record input
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [tha_pkg::IN_DATA_W-1:0]     s_tdata,  // src_rank, dst_rank, msg_bytes
  input  logic [0:0]                        s_tuser,  // first_record
  // result output
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [tha_pkg::OUT_DATA_W-1:0]    m_tdata,  // hops, local_total, remote_total,
                                                      // hop_byte_total
  output logic [0:0]                        m_tuser,  // rank_error
  // thread count write channel
  input  logic                              cfg_tvalid,
  output logic                              cfg_tready,
  input  logic [tha_pkg::THR_W-1:0]         cfg_tdata  // threads per CPU
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_A,
    ST_DIV_B,
    ST_COORD,
    ST_ACC,
    ST_OUT
  } state_t;

  state_t state;

  // configuration
  logic [tha_pkg::TCNT_W-1:0]   eff_t;
  logic [tha_pkg::CMP_W-1:0]    machine;
  logic [tha_pkg::TCNT_W-1:0]   t_new;

  // record fields as they arrive
  logic [tha_pkg::RANK_W-1:0]   in_src;
  logic [tha_pkg::RANK_W-1:0]   in_dst;
  logic [tha_pkg::BYTES_W-1:0]  in_bytes;
  logic                         in_err;

  // held record
  logic [tha_pkg::RANK_W-1:0]   src_q;
  logic [tha_pkg::RANK_W-1:0]   dst_q;
  logic [tha_pkg::BYTES_W-1:0]  bytes_q;
  logic                         err_q;
  logic [tha_pkg::RANK_W-1:0]   qa;
  logic [tha_pkg::RANK_W-1:0]   qb;
  logic [tha_pkg::HOP_W-1:0]    hops_q;

  // unit hookup
  logic                         div_start;
  logic                         div_done;
  logic [tha_pkg::RANK_W-1:0]   div_dividend;
  logic [tha_pkg::RANK_W-1:0]   div_quot;
  logic                         coord_valid;
  logic                         coord_done;
  logic [tha_pkg::HOP_W-1:0]    hop_sum;
  tha_pkg::acc_ctrl_t           acc_ctrl;
  logic                         acc_done;
  logic [tha_pkg::TOTAL_W-1:0]  local_total;
  logic [tha_pkg::TOTAL_W-1:0]  remote_total;
  logic [tha_pkg::TOTAL_W-1:0]  hop_byte_total;

  // Clamp the written thread count into 1..MAX_THREADS.
  function automatic logic [tha_pkg::TCNT_W-1:0] clamp_threads(
    input logic [tha_pkg::THR_W-1:0] v
  );
    if (v == '0) begin
      return tha_pkg::TCNT_W'(1);
    end else if (v > tha_pkg::THR_W'(tha_pkg::MAX_THREADS)) begin
      return tha_pkg::TCNT_W'(tha_pkg::MAX_THREADS);
    end
    return tha_pkg::TCNT_W'(v);
  endfunction

  // ---------------------------------------------------------------------
  // Configuration: keep the clamped thread count and the machine size
  // (nodes x CPUs x threads) ready, so the range check is a plain compare.
  // ---------------------------------------------------------------------
  assign cfg_tready = 1'b1;
  assign t_new      = clamp_threads(cfg_tdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_t   <= tha_pkg::TCNT_W'(tha_pkg::THR_RESET);
      machine <= tha_pkg::CMP_W'(tha_pkg::NODES_ALL * tha_pkg::CPUS_PER_NODE
                                 * tha_pkg::THR_RESET);
    end else if (cfg_tvalid && cfg_tready) begin
      eff_t   <= t_new;
      machine <= tha_pkg::CMP_W'(tha_pkg::NODES_ALL * tha_pkg::CPUS_PER_NODE)
               * tha_pkg::CMP_W'(t_new);
    end
  end

  // ---------------------------------------------------------------------
  // Unpack the record and flag ranks beyond the machine.
  // ---------------------------------------------------------------------
  assign in_src   = s_tdata[tha_pkg::RANK_W-1:0];
  assign in_dst   = s_tdata[2*tha_pkg::RANK_W-1:tha_pkg::RANK_W];
  assign in_bytes = s_tdata[2*tha_pkg::RANK_W+tha_pkg::BYTES_W-1:2*tha_pkg::RANK_W];
  assign in_err   = (tha_pkg::CMP_W'(in_src) >= machine)
                 || (tha_pkg::CMP_W'(in_dst) >= machine);

  assign s_tready = (state == ST_IDLE);

  // ---------------------------------------------------------------------
  // Sequencer: divide source then destination rank by the thread count,
  // run both node numbers through the coordinate pipeline, update the
  // totals, then park the result in the output register.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      div_start   <= 1'b0;
      coord_valid <= 1'b0;
      acc_ctrl    <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      div_start   <= 1'b0;
      coord_valid <= 1'b0;
      acc_ctrl    <= '0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            acc_ctrl.clear <= s_tuser[0];
            if (in_err) begin
              // flagged: no arithmetic, just let the clear settle
              acc_ctrl.start <= 1'b1;
              acc_ctrl.skip  <= 1'b1;
              state          <= ST_ACC;
            end else begin
              div_start <= 1'b1;
              state     <= ST_DIV_A;
            end
          end
        end
        ST_DIV_A: begin
          if (div_done) begin
            div_start <= 1'b1;
            state     <= ST_DIV_B;
          end
        end
        ST_DIV_B: begin
          if (div_done) begin
            coord_valid <= 1'b1;
            state       <= ST_COORD;
          end
        end
        ST_COORD: begin
          if (coord_done) begin
            acc_ctrl.start <= 1'b1;
            state          <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (acc_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= tha_pkg::OUT_DATA_W'({hop_byte_total, remote_total, local_total,
                                              tha_pkg::HOPS_OUT_W'(hops_q)});
            m_tuser  <= err_q;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Record payload and intermediate results.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      src_q   <= in_src;
      dst_q   <= in_dst;
      bytes_q <= in_bytes;
      err_q   <= in_err;
      hops_q  <= '0;
    end
    if (state == ST_DIV_A && div_done) begin
      qa <= div_quot;
    end
    if (state == ST_DIV_B && div_done) begin
      qb <= div_quot;
    end
    // rank / threads gives node and CPU together: equal quotients mean
    // same node and same CPU, so zero hops
    if (state == ST_COORD && coord_done) begin
      hops_q <= (qa == qb) ? '0 : hop_sum;
    end
  end

  assign div_dividend = (state == ST_DIV_B) ? dst_q : src_q;

  tha_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (eff_t),
    .done     (div_done),
    .quotient (div_quot)
  );

  // drop the CPU bit to get the node number
  tha_coord u_coord (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (coord_valid),
    .node_a    (tha_pkg::NODE_W'(qa >> 1)),
    .node_b    (tha_pkg::NODE_W'(qb >> 1)),
    .out_valid (coord_done),
    .hop_sum   (hop_sum)
  );

  tha_acc u_acc (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (acc_ctrl),
    .hops           (hops_q),
    .msg_bytes      (bytes_q),
    .done           (acc_done),
    .local_total    (local_total),
    .remote_total   (remote_total),
    .hop_byte_total (hop_byte_total)
  );

  // one record in flight: the input closes right after a transaction
  `THA_ASSERT(a_one_record, clk, rst, (s_tvalid && s_tready) |=> !s_tready)
  // the divider only reports back while the sequencer waits on it
  `THA_ASSERT(a_div_in_seq, clk, rst, div_done |-> (state == ST_DIV_A || state == ST_DIV_B))
  // a flagged record never carries a hop count
  `THA_ASSERT(a_err_no_hops, clk, rst,
    (m_tvalid && m_tuser[0]) |-> (m_tdata[tha_pkg::HOPS_OUT_W-1:0] == '0))

endmodule
